// ===== rtl/drvg_pkg.sv =====
package drvg_pkg;

    localparam int COORD_W   = 32;
    localparam int SEG_W     = 7;
    localparam int PROD_W    = 66;
    localparam int CNT_W     = 6;

    localparam logic [SEG_W-1:0] MAX_SEG   = 7'd64;
    localparam logic [SEG_W-1:0] SEG_RESET = 7'd20;
    localparam logic signed [31:0] COS_RESET = 32'sd1021189159;
    localparam logic signed [31:0] SIN_RESET = 32'sd331804471;

    localparam logic signed [31:0] ONE_Q30  = 32'sd1073741824;
    localparam logic signed [31:0] DIAG_Q30 = 32'sd759250125;
    localparam logic signed [31:0] EPS_COMP = 32'sd10737;
    localparam logic [63:0] DIR_EPS_SQ = 64'd42949;
    localparam logic [63:0] TAN_EPS_SQ = 64'd11529215046068;
    localparam logic [63:0] TAN_MIN_SQ = 64'd115292150460685;

    localparam logic [CNT_W-1:0] SQRT_LAST = 6'd31;
    localparam logic [CNT_W-1:0] DIV_LAST  = 6'd30;

    localparam logic [1:0] CFG_SEG = 2'd0;
    localparam logic [1:0] CFG_COS = 2'd1;
    localparam logic [1:0] CFG_SIN = 2'd2;

    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_DIAG = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_SQ_VEC, OP_SUM_VEC, OP_EPS, OP_SHIFT, OP_SQ_U,
        OP_SUM_U, OP_SQRT, OP_DIV_INIT, OP_DIV, OP_DIV_END, OP_CROSS_MUL,
        OP_CROSS_SUB, OP_AXIS_NEXT, OP_ROT_INIT, OP_V_MUL1, OP_V_MUL2,
        OP_V_MUL3, OP_V_OUT
    } t_op;

    typedef enum logic [1:0] {
        X_AXIS, X_VEC, X_TAN
    } t_xsel;

    typedef enum logic [4:0] {
        S_IDLE, S_SQ, S_SUM, S_CHK, S_AXIS, S_EPS, S_SHIFT, S_USQ, S_USUM,
        S_SQRT, S_DIVI, S_DIV, S_DIVE, S_CR1M, S_CR1S, S_CR2M, S_CR2S,
        S_CR3M, S_CR3S, S_ROT, S_VM1, S_VM2, S_VM3, S_VOUT
    } t_state;

    typedef struct packed {
        t_op   op;
        logic  tgt_tan;
        t_xsel xsel;
    } t_cmd;

    typedef struct packed {
        logic eps_hit;
        logic u_low;
        logic tan_ok;
        logic seg_zero;
        logic last;
        logic out_free;
    } t_sts;

    function automatic logic signed [31:0] axis_comp(input logic [1:0] idx,
                                                     input logic [1:0] j);
        logic signed [31:0] v;
        v = 32'sd0;
        unique case (idx)
            AXIS_X:    v = (j == 2'd0) ? ONE_Q30 : 32'sd0;
            AXIS_DIAG: v = (j == 2'd1) ? 32'sd0 : DIAG_Q30;
            default:   v = (j == 2'd2) ? ONE_Q30 : 32'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [37:0] x);
        logic signed [31:0] r;
        if (x > 38'sd2147483647)
            r = 32'sh7fffffff;
        else if (x < -38'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

    function automatic logic signed [32:0] mag33(input logic signed [31:0] x);
        logic signed [32:0] e;
        e = {x[31], x};
        return x[31] ? -e : e;
    endfunction

endpackage

// ===== rtl/drvg_ctrl.sv =====
module drvg_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  drvg_pkg::t_sts i_sts,
    output drvg_pkg::t_cmd o_cmd,
    output logic           o_busy
);

    drvg_pkg::t_state r_state, n_state;
    logic r_tgt, n_tgt;
    logic [drvg_pkg::CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= drvg_pkg::S_IDLE;
            r_tgt   <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_tgt   <= n_tgt;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_tgt   = r_tgt;
        n_cnt   = r_cnt;
        unique case (r_state)
            drvg_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = drvg_pkg::S_SQ;
                    n_tgt   = 1'b0;
                end
            end
            drvg_pkg::S_SQ:  n_state = drvg_pkg::S_SUM;
            drvg_pkg::S_SUM: n_state = drvg_pkg::S_CHK;
            drvg_pkg::S_CHK: begin
                if (r_tgt && !i_sts.tan_ok)
                    n_state = drvg_pkg::S_AXIS;
                else if (i_sts.eps_hit)
                    n_state = drvg_pkg::S_EPS;
                else
                    n_state = drvg_pkg::S_SHIFT;
            end
            drvg_pkg::S_AXIS: n_state = drvg_pkg::S_CR1M;
            drvg_pkg::S_EPS, drvg_pkg::S_DIVE: begin
                if (r_tgt) begin
                    n_state = drvg_pkg::S_CR3M;
                end else begin
                    n_state = drvg_pkg::S_CR1M;
                    n_tgt   = 1'b1;
                end
            end
            drvg_pkg::S_SHIFT: if (!i_sts.u_low) n_state = drvg_pkg::S_USQ;
            drvg_pkg::S_USQ: n_state = drvg_pkg::S_USUM;
            drvg_pkg::S_USUM: begin
                n_state = drvg_pkg::S_SQRT;
                n_cnt   = '0;
            end
            drvg_pkg::S_SQRT: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == drvg_pkg::SQRT_LAST) n_state = drvg_pkg::S_DIVI;
            end
            drvg_pkg::S_DIVI: begin
                n_state = drvg_pkg::S_DIV;
                n_cnt   = '0;
            end
            drvg_pkg::S_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == drvg_pkg::DIV_LAST) n_state = drvg_pkg::S_DIVE;
            end
            drvg_pkg::S_CR1M: n_state = drvg_pkg::S_CR1S;
            drvg_pkg::S_CR1S: n_state = drvg_pkg::S_CR2M;
            drvg_pkg::S_CR2M: n_state = drvg_pkg::S_CR2S;
            drvg_pkg::S_CR2S: n_state = drvg_pkg::S_SQ;
            drvg_pkg::S_CR3M: n_state = drvg_pkg::S_CR3S;
            drvg_pkg::S_CR3S: n_state = drvg_pkg::S_ROT;
            drvg_pkg::S_ROT: begin
                n_state = i_sts.seg_zero ? drvg_pkg::S_IDLE : drvg_pkg::S_VM1;
            end
            drvg_pkg::S_VM1: n_state = drvg_pkg::S_VM2;
            drvg_pkg::S_VM2: n_state = drvg_pkg::S_VM3;
            drvg_pkg::S_VM3: n_state = drvg_pkg::S_VOUT;
            drvg_pkg::S_VOUT: begin
                if (i_sts.out_free)
                    n_state = i_sts.last ? drvg_pkg::S_IDLE : drvg_pkg::S_VM1;
            end
            default: n_state = drvg_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op      = drvg_pkg::OP_NONE;
        o_cmd.tgt_tan = r_tgt;
        o_cmd.xsel    = drvg_pkg::X_AXIS;
        o_busy        = (r_state != drvg_pkg::S_IDLE);
        unique case (r_state)
            drvg_pkg::S_IDLE: if (i_valid) o_cmd.op = drvg_pkg::OP_LOAD;
            drvg_pkg::S_SQ:   o_cmd.op = drvg_pkg::OP_SQ_VEC;
            drvg_pkg::S_SUM:  o_cmd.op = drvg_pkg::OP_SUM_VEC;
            drvg_pkg::S_AXIS: o_cmd.op = drvg_pkg::OP_AXIS_NEXT;
            drvg_pkg::S_EPS:  o_cmd.op = drvg_pkg::OP_EPS;
            drvg_pkg::S_SHIFT: if (i_sts.u_low) o_cmd.op = drvg_pkg::OP_SHIFT;
            drvg_pkg::S_USQ:  o_cmd.op = drvg_pkg::OP_SQ_U;
            drvg_pkg::S_USUM: o_cmd.op = drvg_pkg::OP_SUM_U;
            drvg_pkg::S_SQRT: o_cmd.op = drvg_pkg::OP_SQRT;
            drvg_pkg::S_DIVI: o_cmd.op = drvg_pkg::OP_DIV_INIT;
            drvg_pkg::S_DIV:  o_cmd.op = drvg_pkg::OP_DIV;
            drvg_pkg::S_DIVE: o_cmd.op = drvg_pkg::OP_DIV_END;
            drvg_pkg::S_CR1M: o_cmd.op = drvg_pkg::OP_CROSS_MUL;
            drvg_pkg::S_CR2M: begin
                o_cmd.op   = drvg_pkg::OP_CROSS_MUL;
                o_cmd.xsel = drvg_pkg::X_VEC;
            end
            drvg_pkg::S_CR3M: begin
                o_cmd.op   = drvg_pkg::OP_CROSS_MUL;
                o_cmd.xsel = drvg_pkg::X_TAN;
            end
            drvg_pkg::S_CR1S, drvg_pkg::S_CR2S, drvg_pkg::S_CR3S:
                o_cmd.op = drvg_pkg::OP_CROSS_SUB;
            drvg_pkg::S_ROT:  o_cmd.op = drvg_pkg::OP_ROT_INIT;
            drvg_pkg::S_VM1:  o_cmd.op = drvg_pkg::OP_V_MUL1;
            drvg_pkg::S_VM2:  o_cmd.op = drvg_pkg::OP_V_MUL2;
            drvg_pkg::S_VM3:  o_cmd.op = drvg_pkg::OP_V_MUL3;
            // products are recomputed while the output register is full
            drvg_pkg::S_VOUT: o_cmd.op = i_sts.out_free ? drvg_pkg::OP_V_OUT
                                                        : drvg_pkg::OP_V_MUL3;
            default: o_cmd.op = drvg_pkg::OP_NONE;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == drvg_pkg::S_SQRT) |-> (r_cnt <= drvg_pkg::SQRT_LAST))
        else $error("sqrt step count overrun");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == drvg_pkg::S_DIV) |-> (r_cnt <= drvg_pkg::DIV_LAST))
        else $error("divide step count overrun");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == drvg_pkg::S_CR3M) |-> r_tgt)
        else $error("bitangent built before tangent");

endmodule

// ===== rtl/drvg_dp.sv =====
module drvg_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  drvg_pkg::t_cmd       i_cmd,
    output drvg_pkg::t_sts       o_sts,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic signed [31:0]   i_center_x,
    input  logic signed [31:0]   i_center_y,
    input  logic signed [31:0]   i_center_z,
    input  logic signed [31:0]   i_axis_x,
    input  logic signed [31:0]   i_axis_y,
    input  logic signed [31:0]   i_axis_z,
    input  logic [30:0]          i_radius,
    input  logic                 i_stall,
    output logic                 o_valid,
    output logic signed [31:0]   o_vert_x,
    output logic signed [31:0]   o_vert_y,
    output logic signed [31:0]   o_vert_z,
    output logic                 o_last
);

    logic [drvg_pkg::SEG_W-1:0] r_seg;
    logic signed [31:0] r_scos, r_ssin;

    logic signed [31:0] r_cen [3];
    logic [30:0]        r_rad;
    logic signed [31:0] r_vec [3];
    logic signed [31:0] r_nrm [3];
    logic signed [31:0] r_tan [3];
    logic [31:0]        r_u [3];
    logic [63:0]        r_sq;
    logic signed [drvg_pkg::PROD_W-1:0] r_p [6];
    logic [63:0]        r_x, r_res, r_bit;
    logic [32:0]        r_len;
    logic [32:0]        r_rem [3];
    logic [30:0]        r_lb [3];
    logic [30:0]        r_q [3];
    logic [1:0]         r_axis;
    logic signed [31:0] r_cos, r_sin, r_rc, r_rs;
    logic [drvg_pkg::SEG_W-1:0] r_k;

    logic signed [32:0] ma [6];
    logic signed [32:0] mb [6];
    logic signed [31:0] bsel [3];
    logic [drvg_pkg::SEG_W-1:0] nseg;
    logic [63:0] sq_sum, rt;
    logic signed [37:0] vsum [3];
    logic signed [66:0] cdiff [3];
    logic [33:0] dt [3];
    logic load_out;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg  <= drvg_pkg::SEG_RESET;
            r_scos <= drvg_pkg::COS_RESET;
            r_ssin <= drvg_pkg::SIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                drvg_pkg::CFG_SEG: r_seg  <= i_cfg_data[drvg_pkg::SEG_W-1:0];
                drvg_pkg::CFG_COS: r_scos <= i_cfg_data;
                drvg_pkg::CFG_SIN: r_ssin <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign nseg = (r_seg > drvg_pkg::MAX_SEG) ? drvg_pkg::MAX_SEG : r_seg;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            unique case (i_cmd.xsel)
                drvg_pkg::X_VEC: bsel[j] = r_vec[j];
                drvg_pkg::X_TAN: bsel[j] = r_tan[j];
                default:         bsel[j] = drvg_pkg::axis_comp(r_axis, 2'(j));
            endcase
        end
    end

    // multiplier operand select
    always_comb begin
        for (int j = 0; j < 6; j++) begin
            ma[j] = '0;
            mb[j] = '0;
        end
        unique case (i_cmd.op)
            drvg_pkg::OP_SQ_VEC: begin
                for (int j = 0; j < 3; j++) begin
                    ma[j] = drvg_pkg::mag33(r_vec[j]);
                    mb[j] = drvg_pkg::mag33(r_vec[j]);
                end
            end
            drvg_pkg::OP_SQ_U: begin
                for (int j = 0; j < 3; j++) begin
                    ma[j] = {1'b0, r_u[j]};
                    mb[j] = {1'b0, r_u[j]};
                end
            end
            drvg_pkg::OP_CROSS_MUL: begin
                ma[0] = 33'(r_nrm[1]); mb[0] = 33'(bsel[2]);
                ma[1] = 33'(r_nrm[2]); mb[1] = 33'(bsel[1]);
                ma[2] = 33'(r_nrm[2]); mb[2] = 33'(bsel[0]);
                ma[3] = 33'(r_nrm[0]); mb[3] = 33'(bsel[2]);
                ma[4] = 33'(r_nrm[0]); mb[4] = 33'(bsel[1]);
                ma[5] = 33'(r_nrm[1]); mb[5] = 33'(bsel[0]);
            end
            drvg_pkg::OP_V_MUL1: begin
                ma[0] = {2'b0, r_rad};  mb[0] = 33'(r_cos);
                ma[1] = {2'b0, r_rad};  mb[1] = 33'(r_sin);
                ma[2] = 33'(r_scos);    mb[2] = 33'(r_cos);
                ma[3] = 33'(r_ssin);    mb[3] = 33'(r_sin);
                ma[4] = 33'(r_ssin);    mb[4] = 33'(r_cos);
                ma[5] = 33'(r_scos);    mb[5] = 33'(r_sin);
            end
            drvg_pkg::OP_V_MUL3: begin
                for (int j = 0; j < 3; j++) begin
                    ma[2*j]   = 33'(r_rc); mb[2*j]   = 33'(r_tan[j]);
                    ma[2*j+1] = 33'(r_rs); mb[2*j+1] = 33'(r_vec[j]);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 6; j++) r_p[j] <= ma[j] * mb[j];
    end

    assign sq_sum = r_p[0][63:0] + r_p[1][63:0] + r_p[2][63:0];
    assign rt     = r_res + r_bit;

    always_comb begin
        cdiff[0] = {r_p[0][65], r_p[0]} - {r_p[1][65], r_p[1]};
        cdiff[1] = {r_p[2][65], r_p[2]} - {r_p[3][65], r_p[3]};
        cdiff[2] = {r_p[4][65], r_p[4]} - {r_p[5][65], r_p[5]};
        for (int j = 0; j < 3; j++) begin
            vsum[j] = 38'(r_cen[j]) + 38'($signed(r_p[2*j][65:30]))
                      + 38'($signed(r_p[2*j+1][65:30]));
            dt[j]   = {r_rem[j], r_lb[j][30]};
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            drvg_pkg::OP_LOAD: begin
                r_cen[0] <= i_center_x;
                r_cen[1] <= i_center_y;
                r_cen[2] <= i_center_z;
                r_vec[0] <= i_axis_x;
                r_vec[1] <= i_axis_y;
                r_vec[2] <= i_axis_z;
                r_rad    <= i_radius;
                r_axis   <= drvg_pkg::AXIS_X;
            end
            drvg_pkg::OP_SUM_VEC: begin
                r_sq <= sq_sum;
                for (int j = 0; j < 3; j++) r_u[j] <= 32'(drvg_pkg::mag33(r_vec[j]));
            end
            drvg_pkg::OP_AXIS_NEXT: r_axis <= r_axis + 1'b1;
            drvg_pkg::OP_EPS: begin
                for (int j = 0; j < 3; j++) begin
                    if (i_cmd.tgt_tan) r_tan[j] <= drvg_pkg::EPS_COMP;
                    else               r_nrm[j] <= drvg_pkg::EPS_COMP;
                end
            end
            drvg_pkg::OP_SHIFT: begin
                for (int j = 0; j < 3; j++) r_u[j] <= {r_u[j][30:0], 1'b0};
            end
            drvg_pkg::OP_SUM_U: begin
                r_x   <= sq_sum;
                r_res <= '0;
                r_bit <= 64'h4000_0000_0000_0000;
            end
            drvg_pkg::OP_SQRT: begin
                if (r_x >= rt) begin
                    r_x   <= r_x - rt;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            drvg_pkg::OP_DIV_INIT: begin
                r_len <= r_res[32:0];
                for (int j = 0; j < 3; j++) begin
                    r_rem[j] <= {2'b0, r_u[j][31:1]};
                    r_lb[j]  <= {r_u[j][0], 30'b0};
                    r_q[j]   <= '0;
                end
            end
            drvg_pkg::OP_DIV: begin
                for (int j = 0; j < 3; j++) begin
                    if (dt[j] >= {1'b0, r_len}) begin
                        r_rem[j] <= 33'(dt[j] - {1'b0, r_len});
                        r_q[j]   <= {r_q[j][29:0], 1'b1};
                    end else begin
                        r_rem[j] <= dt[j][32:0];
                        r_q[j]   <= {r_q[j][29:0], 1'b0};
                    end
                    r_lb[j] <= {r_lb[j][29:0], 1'b0};
                end
            end
            drvg_pkg::OP_DIV_END: begin
                for (int j = 0; j < 3; j++) begin
                    if (i_cmd.tgt_tan)
                        r_tan[j] <= r_vec[j][31] ? -$signed({1'b0, r_q[j]})
                                                 :  $signed({1'b0, r_q[j]});
                    else
                        r_nrm[j] <= r_vec[j][31] ? -$signed({1'b0, r_q[j]})
                                                 :  $signed({1'b0, r_q[j]});
                end
            end
            drvg_pkg::OP_CROSS_SUB: begin
                for (int j = 0; j < 3; j++) r_vec[j] <= cdiff[j][61:30];
            end
            drvg_pkg::OP_ROT_INIT: begin
                r_cos <= '0;
                r_sin <= drvg_pkg::ONE_Q30;
                r_k   <= '0;
            end
            drvg_pkg::OP_V_MUL2: begin
                r_rc  <= drvg_pkg::sat32(38'($signed(r_p[0][65:30])));
                r_rs  <= drvg_pkg::sat32(38'($signed(r_p[1][65:30])));
                r_cos <= drvg_pkg::sat32(38'($signed(r_p[2][65:30]))
                                         - 38'($signed(r_p[3][65:30])));
                r_sin <= drvg_pkg::sat32(38'($signed(r_p[4][65:30]))
                                         + 38'($signed(r_p[5][65:30])));
            end
            drvg_pkg::OP_V_OUT: r_k <= r_k + 1'b1;
            default: ;
        endcase
    end

    // output register
    assign load_out = (i_cmd.op == drvg_pkg::OP_V_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (load_out) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_vert_x <= drvg_pkg::sat32(vsum[0]);
            o_vert_y <= drvg_pkg::sat32(vsum[1]);
            o_vert_z <= drvg_pkg::sat32(vsum[2]);
            o_last   <= (r_k == nseg - 1'b1);
        end
    end

    always_comb begin
        o_sts.eps_hit  = (r_sq <= (i_cmd.tgt_tan ? drvg_pkg::TAN_EPS_SQ
                                                 : drvg_pkg::DIR_EPS_SQ))
                         || ((r_u[0] | r_u[1] | r_u[2]) == '0);
        o_sts.u_low    = (r_u[0][31:30] == 2'b0) && (r_u[1][31:30] == 2'b0)
                         && (r_u[2][31:30] == 2'b0);
        o_sts.tan_ok   = (r_sq >= drvg_pkg::TAN_MIN_SQ) || (r_axis == drvg_pkg::AXIS_Z);
        o_sts.seg_zero = (nseg == '0);
        o_sts.last     = (r_k == nseg - 1'b1);
        o_sts.out_free = !o_valid || !i_stall;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == drvg_pkg::OP_DIV) |-> (r_rem[0] < r_len))
        else $error("divider remainder not below divisor");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == drvg_pkg::OP_DIV_END) |->
        (r_q[0] <= 31'h4000_0000) && (r_q[1] <= 31'h4000_0000) && (r_q[2] <= 31'h4000_0000))
        else $error("normalized component above one");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == drvg_pkg::OP_V_OUT) |-> (r_k < nseg))
        else $error("vertex count overrun");

endmodule

// ===== rtl/disc_ring_vertex_generator.sv =====
// Disc ring vertex generator.
// Input channel (i_valid / o_stall): one item holds a ring centre, an axis and
// a radius, Q16.16. It is taken when i_valid is high and o_stall is low;
// o_stall stays high until the last vertex of the ring has been loaded.
// Output channel (o_valid / i_stall): min(segment_count, 64) vertex items per
// input, o_last set on the final one. No vertex when segment_count is zero.
// Config channel (i_cfg_valid / o_cfg_ready): index 0 segment_count,
// 1 step cosine, 2 step sine (Q2.30); always ready, write only while idle.
// Frame setup runs two normalizations, each a bit-per-cycle shift, a 32-step
// square root and a 31-step divider, plus cross products that are redone for
// each fallback axis; a vector that falls back to epsilon skips the shift,
// root and divide. Each vertex then passes through the six shared multipliers
// in the steps VM1, VM2, VM3 and VOUT.
// Reset restores the config defaults (20, cos/sin of 18 degrees) and empties
// the output register. A stalled output vertex holds and the vertex sequencer
// waits on it.
module disc_ring_vertex_generator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_center_x,
    input  logic signed [31:0] i_center_y,
    input  logic signed [31:0] i_center_z,
    input  logic signed [31:0] i_axis_x,
    input  logic signed [31:0] i_axis_y,
    input  logic signed [31:0] i_axis_z,
    input  logic [30:0]        i_radius,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_vert_x,
    output logic signed [31:0] o_vert_y,
    output logic signed [31:0] o_vert_z,
    output logic               o_last,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    drvg_pkg::t_cmd cmd;
    drvg_pkg::t_sts sts;
    logic busy;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = busy;

    drvg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    drvg_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_center_x  (i_center_x),
        .i_center_y  (i_center_y),
        .i_center_z  (i_center_z),
        .i_axis_x    (i_axis_x),
        .i_axis_y    (i_axis_y),
        .i_axis_z    (i_axis_z),
        .i_radius    (i_radius),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_vert_x    (o_vert_x),
        .o_vert_y    (o_vert_y),
        .o_vert_z    (o_vert_z),
        .o_last      (o_last)
    );

endmodule

// ===== sim/disc_ring_vertex_generator_tb.sv =====
module disc_ring_vertex_generator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef longint t_vec3 [3];

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               last;
    } t_vertex;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [31:0] i_center_x = '0;
    logic signed [31:0] i_center_y = '0;
    logic signed [31:0] i_center_z = '0;
    logic signed [31:0] i_axis_x = '0;
    logic signed [31:0] i_axis_y = '0;
    logic signed [31:0] i_axis_z = '0;
    logic [30:0]        i_radius = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_vert_x;
    logic signed [31:0] o_vert_y;
    logic signed [31:0] o_vert_z;
    logic               o_last;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = drvg_pkg::CFG_SEG;
    logic [31:0]        i_cfg_data = '0;

    disc_ring_vertex_generator DUT (.*);

    t_vertex vert_q [$];
    int      mismatches = 0;
    bit      in_idle = 1'b1;
    bit      out_idle = 1'b1;
    int      hold_len = 0;

    logic [6:0] seg_count = drvg_pkg::SEG_RESET;
    longint     rot_step_cos = drvg_pkg::COS_RESET;
    longint     rot_step_sin = drvg_pkg::SIN_RESET;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #30ms;
        $display("Test completed with failures");
        $finish;
    end

    // --- vertex predictor ---
    function automatic longint sat_s32(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint unsigned mag(input longint x);
        return (x < 0) ? longint'(-x) : longint'(x);
    endfunction

    function automatic longint unsigned sq_len(input t_vec3 v);
        longint unsigned s;
        s = 0;
        for (int i = 0; i < 3; i++) s += mag(v[i]) * mag(v[i]);
        return s;
    endfunction

    function automatic longint unsigned isqrt64(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic void unit_vec(input t_vec3 v, input longint unsigned eps,
                                     output t_vec3 o);
        longint unsigned u [3];
        longint unsigned m;
        longint unsigned len;
        longint q;
        m = 0;
        for (int i = 0; i < 3; i++) begin
            u[i] = mag(v[i]);
            if (u[i] > m) m = u[i];
        end
        if (sq_len(v) <= eps || m == 0) begin
            for (int i = 0; i < 3; i++) o[i] = drvg_pkg::EPS_COMP;
            return;
        end
        while (m > (64'd1 << 31)) begin
            for (int i = 0; i < 3; i++) u[i] >>= 1;
            m >>= 1;
        end
        while (m < (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) u[i] <<= 1;
            m <<= 1;
        end
        len = isqrt64(u[0] * u[0] + u[1] * u[1] + u[2] * u[2]);
        for (int i = 0; i < 3; i++) begin
            q = longint'((u[i] << 30) / len);
            o[i] = (v[i] < 0) ? -q : q;
        end
    endfunction

    function automatic void cross30(input t_vec3 a, input t_vec3 b, output t_vec3 o);
        o[0] = (a[1] * b[2] - a[2] * b[1]) >>> 30;
        o[1] = (a[2] * b[0] - a[0] * b[2]) >>> 30;
        o[2] = (a[0] * b[1] - a[1] * b[0]) >>> 30;
    endfunction

    function automatic void predict_ring(input t_vec3 cen, input t_vec3 dir,
                                         input longint rad);
        t_vec3 nrm, ax, perp, traw, tng, btn;
        longint ca, sa, rc, rs, nc, ns, p;
        int n;
        t_vertex vtx;
        longint pos [3];
        unit_vec(dir, drvg_pkg::DIR_EPS_SQ, nrm);
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) ax[j] = drvg_pkg::axis_comp(2'(k), 2'(j));
            cross30(nrm, ax, perp);
            cross30(nrm, perp, traw);
            if (sq_len(traw) >= drvg_pkg::TAN_MIN_SQ) break;
        end
        unit_vec(traw, drvg_pkg::TAN_EPS_SQ, tng);
        cross30(nrm, tng, btn);
        n = (seg_count > drvg_pkg::MAX_SEG) ? drvg_pkg::MAX_SEG : seg_count;
        ca = 0;
        sa = drvg_pkg::ONE_Q30;
        for (int k = 0; k < n; k++) begin
            rc = sat_s32((rad * ca) >>> 30);
            rs = sat_s32((rad * sa) >>> 30);
            for (int i = 0; i < 3; i++) begin
                p = cen[i] + ((rc * tng[i]) >>> 30) + ((rs * btn[i]) >>> 30);
                pos[i] = sat_s32(p);
            end
            vtx.x = pos[0][31:0];
            vtx.y = pos[1][31:0];
            vtx.z = pos[2][31:0];
            vtx.last = (k == n - 1);
            vert_q.push_back(vtx);
            nc = ((rot_step_cos * ca) >>> 30) - ((rot_step_sin * sa) >>> 30);
            ns = ((rot_step_sin * ca) >>> 30) + ((rot_step_cos * sa) >>> 30);
            ca = sat_s32(nc);
            sa = sat_s32(ns);
        end
    endfunction

    // --- vertex checker ---
    initial begin
        t_vertex e;
        forever begin
            @(negedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (vert_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected vertex %0d %0d %0d last %0b",
                                 o_vert_x, o_vert_y, o_vert_z, o_last);
                end else begin
                    e = vert_q.pop_front();
                    if (e.x !== o_vert_x || e.y !== o_vert_y || e.z !== o_vert_z ||
                        e.last !== o_last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"vertex mismatch: exp %0d %0d %0d last %0b, ",
                                      "got %0d %0d %0d last %0b"},
                                     e.x, e.y, e.z, e.last,
                                     o_vert_x, o_vert_y, o_vert_z, o_last);
                    end
                end
            end
        end
    end

    // --- output stall generator ---
    initial begin
        int n;
        bit got;
        @(posedge i_rst_n);
        forever begin
            do begin
                @(negedge i_clk);
                got = o_valid && !i_stall;
                @(posedge i_clk);
            end while (!got);
            n = (hold_len > 0) ? hold_len : (out_idle ? $urandom_range(0, 10) : 0);
            hold_len = 0;
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // --- stimulus tasks ---
    task automatic send_ring(input logic signed [31:0] cx, cy, cz, ax, ay, az,
                             input logic [30:0] r);
        int gap;
        bit ok;
        t_vec3 cen, dir;
        gap = in_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_center_x <= cx;
        i_center_y <= cy;
        i_center_z <= cz;
        i_axis_x <= ax;
        i_axis_y <= ay;
        i_axis_z <= az;
        i_radius <= r;
        i_valid <= 1'b1;
        do begin
            @(negedge i_clk);
            ok = !o_stall;
            @(posedge i_clk);
        end while (!ok);
        cen[0] = cx; cen[1] = cy; cen[2] = cz;
        dir[0] = ax; dir[1] = ay; dir[2] = az;
        predict_ring(cen, dir, longint'(r));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (vert_q.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        bit rdy;
        drain();
        i_cfg_index <= idx;
        i_cfg_data <= data;
        i_cfg_valid <= 1'b1;
        do begin
            @(negedge i_clk);
            rdy = o_cfg_ready;
            @(posedge i_clk);
        end while (!rdy);
        i_cfg_valid <= 1'b0;
        case (idx)
            drvg_pkg::CFG_SEG: seg_count = data[6:0];
            drvg_pkg::CFG_COS: rot_step_cos = longint'(signed'(data));
            drvg_pkg::CFG_SIN: rot_step_sin = longint'(signed'(data));
            default: ;
        endcase
    endtask

    task automatic rand_ring();
        logic signed [31:0] a [3];
        logic signed [31:0] c [3];
        logic [30:0] r;
        int kind;
        int k;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++) begin
            a[i] = $urandom;
            c[i] = (kind == 9) ? $urandom
                               : $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
        end
        r = (kind >= 8) ? 31'($urandom) : 31'($urandom_range(0, 32'h0040_0000));
        k = $urandom_range(1, 32'h0001_0000);
        case (kind)
            0: begin a[1] = 0; a[2] = 0; end
            1: begin a[0] = k; a[1] = 0; a[2] = k; end
            2: for (int i = 0; i < 3; i++) a[i] = $signed($urandom_range(0, 256)) - 128;
            3: for (int i = 0; i < 3; i++)
                   a[i] = $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
            default: ;
        endcase
        send_ring(c[0], c[1], c[2], a[0], a[1], a[2], r);
    endtask

    task automatic test_directed();
        write_reg(drvg_pkg::CFG_SEG, 32'd4);
        send_ring(0, 0, 0, 0, 0, 0, 31'h0001_0000);
        send_ring(0, 0, 0, 100, 100, 0, 31'h0001_0000);
        send_ring(0, 0, 0, 32'sh0001_0000, 0, 0, 31'h0002_0000);
        send_ring(0, 0, 0, 32'sh0003_0000, 0, 32'sh0003_0000, 31'h0002_0000);
        send_ring(0, 0, 0, -32'sd2147483648, -32'sd2147483648, -32'sd2147483648,
                  31'h7fff_ffff);
        send_ring(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                  32'sh7fff_ffff, 0, 0, 31'h7fff_ffff);
        send_ring(-32'sd2147483648, -32'sd2147483648, -32'sd2147483648,
                  0, 32'sh7fff_ffff, 1, 31'h7fff_ffff);
        send_ring(32'sh1234_5678, -32'sh0765_4321, 5, 3, -7, 11, 31'd0);
        write_reg(drvg_pkg::CFG_SEG, 32'd0);
        send_ring(0, 0, 0, 1, 2, 3, 31'h0001_0000);
        send_ring(7, 8, 9, 0, 0, 0, 31'h0001_0000);
        write_reg(drvg_pkg::CFG_SEG, 32'd1);
        send_ring(7, 8, 9, 1, 2, 3, 31'h0001_0000);
        write_reg(drvg_pkg::CFG_SEG, 32'd127);
        send_ring(0, 0, 0, 0, 1, 0, 31'h0010_0000);
        write_reg(drvg_pkg::CFG_SEG, 32'd64);
        send_ring(0, 0, 0, 0, 0, -1, 31'h0010_0000);
        // unused register index
        write_reg(2'd3, 32'hffff_ffff);
        write_reg(drvg_pkg::CFG_SEG, 32'd6);
        write_reg(drvg_pkg::CFG_COS, 32'hc000_0000);
        write_reg(drvg_pkg::CFG_SIN, 32'h4000_0000);
        send_ring(0, 0, 0, 1, 1, 1, 31'h0100_0000);
        write_reg(drvg_pkg::CFG_COS, 32'h7fff_ffff);
        write_reg(drvg_pkg::CFG_SIN, 32'h8000_0000);
        send_ring(0, 0, 0, -1, 1, -1, 31'h7fff_ffff);
        write_reg(drvg_pkg::CFG_SIN, 32'h7fff_ffff);
        send_ring(0, 0, 0, 5, 0, 0, 31'h7fff_ffff);
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(drvg_pkg::CFG_SEG, 32'($urandom_range(1, 12)));
            write_reg(drvg_pkg::CFG_COS,
                      $signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000);
            write_reg(drvg_pkg::CFG_SIN,
                      $signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000);
            in_idle = (ph != 2);
            out_idle = (ph != 1);
            for (int i = 0; i < 30; i++) rand_ring();
        end
        in_idle = 1'b1;
        out_idle = 1'b1;
    endtask

    task automatic test_backpressure();
        write_reg(drvg_pkg::CFG_SEG, 32'd20);
        write_reg(drvg_pkg::CFG_COS, drvg_pkg::COS_RESET);
        write_reg(drvg_pkg::CFG_SIN, drvg_pkg::SIN_RESET);
        in_idle = 1'b0;
        hold_len = 600;
        for (int i = 0; i < 5; i++) rand_ring();
        in_idle = 1'b1;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random();
        drain();
        if (mismatches == 0 && vert_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
